// File: hw/rtl/hpt_pkg.sv
// shared constants and types of the homogeneous point transform
`timescale 1ns / 1ps
package hpt_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int IO_W        = 32;
  localparam int REG_W       = 64;
  localparam int NUM_REGS    = 8;
  localparam int CFG_IDX_W   = 4;

  // register indexes, two coefficients to a register
  localparam int REG_ROW0_COLS01 = 0;
  localparam int REG_ROW0_COLS23 = 1;
  localparam int REG_ROW1_COLS01 = 2;
  localparam int REG_ROW1_COLS23 = 3;
  localparam int REG_ROW2_COLS01 = 4;
  localparam int REG_ROW2_COLS23 = 5;
  localparam int REG_ROW3_COLS01 = 6;
  localparam int REG_ROW3_COLS23 = 7;

  // per-item data that rides alongside the divider
  typedef struct packed {
    logic                      divided;
    logic                      sat;
    logic [2:0]                neg;
    logic [2:0]                ov;
    logic [2:0][IO_W-1:0]      val;
  } side_t;
endpackage

// File: hw/rtl/hpt_if.sv
// channel interfaces: point in, result out, register write
`timescale 1ns / 1ps
interface hpt_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] x_in;
  logic [31:0] y_in;
  logic [31:0] z_in;
  modport source (output valid, cmd, x_in, y_in, z_in, input ready);
  modport sink (input valid, cmd, x_in, y_in, z_in, output ready);
endinterface

interface hpt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_out;
  logic [31:0] y_out;
  logic [31:0] z_out;
  logic        divided;
  logic        saturated;
  modport source (output valid, x_out, y_out, z_out, divided, saturated, input ready);
  modport sink (input valid, x_out, y_out, z_out, divided, saturated, output ready);
endinterface

interface hpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/hpt_div_pipe.sv
// pipelined restoring divider, three dividends over one divisor, one quotient bit a stage
`timescale 1ns / 1ps
module hpt_div_pipe #(
  parameter int CW = hpt_pkg::COORD_WIDTH,
  parameter int MW = 2 * hpt_pkg::COORD_WIDTH + 3
) (
  input  logic                  clk,
  input  logic [CW-1:0]         en,
  input  logic [2:0][MW-1:0]    rem_in,
  input  logic [2:0][CW-1:0]    nlow_in,
  input  logic [MW-1:0]         d_in,
  output logic [2:0][CW-1:0]    q_out
);
  logic [2:0][MW-1:0] rem [CW];
  logic [2:0][CW-1:0] nl  [CW];
  logic [2:0][CW-1:0] q   [CW];
  logic [MW-1:0]      d   [CW];

  for (genvar j = 0; j < CW; j++) begin : g_stage
    logic [2:0][MW-1:0] rem_p;
    logic [2:0][CW-1:0] nl_p;
    logic [2:0][CW-1:0] q_p;
    logic [MW-1:0]      d_p;
    logic [2:0][MW-1:0] rem_next;
    logic [2:0][CW-1:0] nl_next;
    logic [2:0][CW-1:0] q_next;

    if (j == 0) begin : g_first
      assign rem_p = rem_in;
      assign nl_p  = nlow_in;
      assign q_p   = '0;
      assign d_p   = d_in;
    end else begin : g_rest
      assign rem_p = rem[j-1];
      assign nl_p  = nl[j-1];
      assign q_p   = q[j-1];
      assign d_p   = d[j-1];
    end

    always_comb begin
      logic [MW:0] t;
      logic        ge;
      for (int i = 0; i < 3; i++) begin
        t  = {rem_p[i], nl_p[i][CW-1]};
        ge = t >= {1'b0, d_p};
        rem_next[i] = ge ? MW'(t - {1'b0, d_p}) : MW'(t);
        q_next[i]   = {q_p[i][CW-2:0], ge};
        nl_next[i]  = nl_p[i] << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j] <= rem_next;
        nl[j]  <= nl_next;
        q[j]   <= q_next;
        d[j]   <= d_p;
      end
    end
  end

  assign q_out = q[CW-1];
endmodule

// File: hw/rtl/homogeneous_point_transform.sv
// top level: 4x4 homogeneous transform with perspective divide
`timescale 1ns / 1ps
// usage
//   cfg    : register writes, index 0..7 = rowR_cols01 (2R) / rowR_cols23 (2R+1), low
//            half the even column; indexes 8..15 are ignored; always ready
//   pt_in  : one word per point, cmd 0 = point with divide, 1 = direction
//   pt_out : one word per input word, in order
// pipeline: COORD_WIDTH+7 register stages: input reg, 12 products, row sums,
//   floor and translation, divide decision, overflow check, one stage per
//   quotient bit, then sign and clamp into the output register
// throughput: one word per cycle while pt_out.ready stays high; the divider
//   issues one quotient bit per stage so it never loops
// each stage has its own valid bit and loads when it is empty or the next
//   stage moves, so bubbles close up and a stalled receiver backs the pipe up
//   one stage at a time; nothing is lost or repeated
// reset: matrix goes to identity and all stage valid bits clear
// registers are meant to be written only while the pipe is empty
module homogeneous_point_transform #(
  parameter int CW = hpt_pkg::COORD_WIDTH,
  parameter int FB = hpt_pkg::FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst,
  hpt_cfg_if.sink    cfg,
  hpt_in_if.sink     pt_in,
  hpt_out_if.source  pt_out
);
  localparam int PRW = 2 * CW;          // product width
  localparam int PW  = PRW + 2;         // row sum of three products
  localparam int RW  = PW + 1;          // row after floor and translation
  localparam int MW  = RW;              // magnitude width
  localparam int NW  = MW + FB + CW;    // dividend compare width
  localparam int NS  = CW + 7;          // stage count
  localparam int DV0 = 6;               // first divider stage
  localparam int IO  = hpt_pkg::IO_W;

  localparam logic signed [RW-1:0] MAXV = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [RW-1:0] MINV = ~MAXV;
  localparam logic [CW-1:0] MAXO = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINO = ~MAXO;

  // ---------------------------------------------------------------- matrix
  logic [hpt_pkg::REG_W-1:0] cfg_regs [hpt_pkg::NUM_REGS];
  logic signed [CW-1:0]      coef [4][4];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++) begin
        cfg_regs[i] <= '0;
      end
      cfg_regs[hpt_pkg::REG_ROW0_COLS01] <= hpt_pkg::REG_W'(1) << FB;
      cfg_regs[hpt_pkg::REG_ROW1_COLS01] <= hpt_pkg::REG_W'(1) << (FB + 32);
      cfg_regs[hpt_pkg::REG_ROW2_COLS23] <= hpt_pkg::REG_W'(1) << FB;
      cfg_regs[hpt_pkg::REG_ROW3_COLS23] <= hpt_pkg::REG_W'(1) << (FB + 32);
    end else if (cfg.valid && cfg.index < hpt_pkg::CFG_IDX_W'(hpt_pkg::NUM_REGS)) begin
      cfg_regs[cfg.index[2:0]] <= cfg.data;
    end
  end

  // column c of row r sits in register 2r + c/2, half chosen by c's low bit
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        coef[r][c] = cfg_regs[3'(2 * r + (c >> 1))][32 * (c & 1) +: CW];
      end
    end
  end

  // ---------------------------------------------------------- flow control
  logic [NS-1:0] valid;
  logic [NS-1:0] adv;

  // a stage loads when it is empty or its word moves on
  always_comb begin
    adv[NS-1] = !valid[NS-1] || pt_out.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !valid[k] || adv[k+1];
    end
  end

  assign pt_in.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) begin
        valid[0] <= pt_in.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // ----------------------------------------------------- stage 0: input reg
  logic                 s0_cmd;
  logic signed [CW-1:0] s0_v [3];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_cmd  <= pt_in.cmd;
      s0_v[0] <= pt_in.x_in[CW-1:0];
      s0_v[1] <= pt_in.y_in[CW-1:0];
      s0_v[2] <= pt_in.z_in[CW-1:0];
    end
  end

  // ------------------------------------------------------ stage 1: products
  logic                  s1_cmd;
  logic signed [PRW-1:0] s1_p [4][3];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_cmd <= s0_cmd;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          s1_p[r][c] <= PRW'(s0_v[c]) * PRW'(coef[r][c]);
        end
      end
    end
  end

  // ------------------------------------------------------ stage 2: row sums
  logic                 s2_cmd;
  logic signed [PW-1:0] s2_sum [4];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_cmd <= s1_cmd;
      for (int r = 0; r < 4; r++) begin
        s2_sum[r] <= PW'(s1_p[r][0]) + PW'(s1_p[r][1]) + PW'(s1_p[r][2]);
      end
    end
  end

  // ------------------------------- stage 3: floor to fixed point, translate
  // a direction skips translation on x, y, z; w is only used for points
  logic                 s3_cmd;
  logic signed [RW-1:0] s3_r [4];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_cmd <= s2_cmd;
      for (int r = 0; r < 4; r++) begin
        s3_r[r] <= RW'(s2_sum[r] >>> FB)
                 + ((r == 3 || !s2_cmd) ? RW'(coef[r][3]) : RW'(0));
      end
    end
  end

  // ---------------------------- stage 4: divide decision, magnitudes, clamp
  hpt_pkg::side_t       s4_side;
  hpt_pkg::side_t       side4_next;
  logic [2:0][MW-1:0]   s4_un;
  logic [MW-1:0]        s4_ud;
  logic signed [RW-1:0] w_m1;

  assign w_m1 = s3_r[3] - (RW'(1) << FB);

  always_comb begin
    logic signed [RW-1:0] cl;
    side4_next = '0;
    // skip the divide when w is within one lsb of zero or of one
    side4_next.divided = !s3_cmd && (s3_r[3] > 1 || s3_r[3] < -1)
                         && (w_m1 > 1 || w_m1 < -1);
    for (int i = 0; i < 3; i++) begin
      side4_next.neg[i] = s3_r[i][RW-1] ^ s3_r[3][RW-1];
      if (s3_r[i] > MAXV) begin
        cl = MAXV;
        side4_next.sat = 1'b1;
      end else if (s3_r[i] < MINV) begin
        cl = MINV;
        side4_next.sat = 1'b1;
      end else begin
        cl = s3_r[i];
      end
      side4_next.val[i] = IO'($signed(cl[CW-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_side <= side4_next;
      for (int i = 0; i < 3; i++) begin
        s4_un[i] <= s3_r[i][RW-1] ? MW'(-s3_r[i]) : MW'(s3_r[i]);
      end
      s4_ud <= s3_r[3][RW-1] ? MW'(-s3_r[3]) : MW'(s3_r[3]);
    end
  end

  // -------------------- stage 5: quotient overflow check, divider preload
  // quotient >= 2^CW exactly when |n| * 2^FB >= |w| * 2^CW
  hpt_pkg::side_t     s5_side;
  logic [2:0][MW-1:0] s5_rem;
  logic [2:0][CW-1:0] s5_nl;
  logic [MW-1:0]      s5_d;

  always_ff @(posedge clk) begin
    logic [NW-1:0]  num;
    hpt_pkg::side_t side5;
    if (adv[5]) begin
      side5 = s4_side;
      for (int i = 0; i < 3; i++) begin
        num = NW'(s4_un[i]) << FB;
        side5.ov[i] = num >= (NW'(s4_ud) << CW);
        s5_rem[i]   <= MW'(num >> CW);
        s5_nl[i]    <= num[CW-1:0];
      end
      s5_side <= side5;
      s5_d    <= s4_ud;
    end
  end

  // ------------------------------------------- stages 6..CW+5: long divide
  logic [2:0][CW-1:0] q_div;
  hpt_pkg::side_t     side_d [CW];

  hpt_div_pipe #(
    .CW (CW),
    .MW (MW)
  ) u_div (
    .clk     (clk),
    .en      (adv[DV0 +: CW]),
    .rem_in  (s5_rem),
    .nlow_in (s5_nl),
    .d_in    (s5_d),
    .q_out   (q_div)
  );

  always_ff @(posedge clk) begin
    if (adv[DV0]) begin
      side_d[0] <= s5_side;
    end
    for (int j = 1; j < CW; j++) begin
      if (adv[DV0+j]) begin
        side_d[j] <= side_d[j-1];
      end
    end
  end

  // --------------------------------------- last stage: sign, clamp, output
  hpt_pkg::side_t      sd;
  logic [2:0][IO-1:0]  fin_val;
  logic                fin_sat;

  assign sd = side_d[CW-1];

  always_comb begin
    logic          s;
    logic [CW-1:0] vq;
    s       = 1'b0;
    vq      = '0;
    fin_sat = sd.sat;
    fin_val = sd.val;
    if (sd.divided) begin
      fin_sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
        s = sd.ov[i] || (sd.neg[i] ? (q_div[i][CW-1] && (|q_div[i][CW-2:0]))
                                   : q_div[i][CW-1]);
        if (s) begin
          vq = sd.neg[i] ? MINO : MAXO;
        end else begin
          vq = sd.neg[i] ? -q_div[i] : q_div[i];
        end
        fin_sat    = fin_sat || s;
        fin_val[i] = IO'($signed(vq));
      end
    end
  end

  logic [IO-1:0] out_x;
  logic [IO-1:0] out_y;
  logic [IO-1:0] out_z;
  logic          out_div;
  logic          out_sat;

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      out_x   <= fin_val[0];
      out_y   <= fin_val[1];
      out_z   <= fin_val[2];
      out_div <= sd.divided;
      out_sat <= fin_sat;
    end
  end

  assign pt_out.valid     = valid[NS-1];
  assign pt_out.x_out     = out_x;
  assign pt_out.y_out     = out_y;
  assign pt_out.z_out     = out_z;
  assign pt_out.divided   = out_div;
  assign pt_out.saturated = out_sat;

  // ---------------------------------------------------------- assertions
  localparam logic [IO-1:0] MAXO_X = IO'($signed(MAXO));
  localparam logic [IO-1:0] MINO_X = IO'($signed(MINO));

  // input only refused while the first stage holds a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !pt_in.ready |-> valid[0])
    else $error("input refused with empty first stage");

  // a saturated word has a coordinate on a range bound
  a_sat_on_bound: assert property (@(posedge clk) disable iff (rst)
    pt_out.valid && pt_out.saturated |->
      (pt_out.x_out == MAXO_X || pt_out.x_out == MINO_X ||
       pt_out.y_out == MAXO_X || pt_out.y_out == MINO_X ||
       pt_out.z_out == MAXO_X || pt_out.z_out == MINO_X))
    else $error("saturated flag without a clamped coordinate");

  // a word held at the output is not overwritten by the stage behind it
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    valid[NS-1] && !pt_out.ready |=> valid[NS-1] && $stable(out_x) && $stable(out_sat))
    else $error("output word changed while stalled");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> valid == '0)
    else $error("pipe not empty after reset");
endmodule

// File: tb/tb.sv
// self-checking testbench of the homogeneous point transform
`timescale 1ns / 1ps
module tb;
  // result word as the block should produce it
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        divided;
    logic        saturated;
  } point_result_t;

  localparam int  LATENCY     = hpt_pkg::COORD_WIDTH + 7;
  localparam int  CYCLE_LIMIT = 600000;
  localparam int  ONE         = 1 << hpt_pkg::FRAC_BITS;
  localparam bit  CMD_POINT   = 1'b0;
  localparam bit  CMD_DIR     = 1'b1;

  logic clk;
  logic rst;

  hpt_cfg_if cfg ();
  hpt_in_if  pt_in ();
  hpt_out_if pt_out ();

  homogeneous_point_transform u_top (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pt_in  (pt_in),
    .pt_out (pt_out)
  );

  // own copy of the matrix registers
  logic [63:0] matrix [hpt_pkg::NUM_REGS];

  point_result_t pending_results [$];
  int            error_count;
  int            cycle_count;
  int            send_idle_pct;
  int            recv_stall_pct;

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // coefficient of row r, column c as held in the registers
  function automatic longint coef(int r, int c);
    logic [63:0] rv;
    rv = matrix[2 * r + c / 2];
    return longint'($signed((c % 2) ? rv[63:32] : rv[31:0]));
  endfunction

  // exact row sum, floored to the fraction bits, plus translation if asked
  function automatic longint row_sum(int r, longint v [3], bit with_trans);
    logic signed [69:0] acc;
    longint             s;
    acc = 0;
    for (int c = 0; c < 3; c++)
      acc = acc + coef(r, c) * v[c];
    s = longint'(acc >>> hpt_pkg::FRAC_BITS);
    if (with_trans)
      s = s + coef(r, 3);
    return s;
  endfunction

  // (n << frac) / d truncated toward zero, magnitude capped at 2^40
  function automatic longint fixed_divide(longint n, longint d);
    logic [127:0] un;
    logic [127:0] ud;
    logic [127:0] q;
    un = (n < 0) ? 128'(-n) : 128'(n);
    ud = (d < 0) ? 128'(-d) : 128'(d);
    q  = (un << hpt_pkg::FRAC_BITS) / ud;
    if (q > (128'd1 << 40))
      q = 128'd1 << 40;
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] clamp_coord(longint v, ref logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic point_result_t transform_point(bit cmd, logic [31:0] x, logic [31:0] y,
                                                    logic [31:0] z);
    point_result_t r;
    longint        v [3];
    longint        res [3];
    longint        w;
    longint        dw;
    logic          sat;
    v[0] = longint'($signed(x));
    v[1] = longint'($signed(y));
    v[2] = longint'($signed(z));
    sat  = 1'b0;
    r.divided = 1'b0;
    for (int i = 0; i < 3; i++)
      res[i] = row_sum(i, v, cmd == CMD_POINT);
    if (cmd == CMD_POINT) begin
      w  = row_sum(3, v, 1'b1);
      dw = w - ONE;
      // no divide when w is within one lsb of zero or of one
      if ((w > 1 || w < -1) && (dw > 1 || dw < -1)) begin
        r.divided = 1'b1;
        for (int i = 0; i < 3; i++)
          res[i] = fixed_divide(res[i], w);
      end
    end
    r.x = clamp_coord(res[0], sat);
    r.y = clamp_coord(res[1], sat);
    r.z = clamp_coord(res[2], sat);
    r.saturated = sat;
    return r;
  endfunction

  // one register write, called at a falling edge
  task automatic write_reg(int idx, logic [63:0] value);
    cfg.valid = 1'b1;
    cfg.index = idx[hpt_pkg::CFG_IDX_W-1:0];
    cfg.data  = value;
    do @(posedge clk); while (!cfg.ready);
    matrix[idx] = value;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // send one point word, with random idle cycles ahead of it
  task automatic send_point(bit cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      pt_in.valid = 1'b0;
      @(negedge clk);
    end
    pt_in.valid = 1'b1;
    pt_in.cmd   = cmd;
    pt_in.x_in  = x;
    pt_in.y_in  = y;
    pt_in.z_in  = z;
    do @(posedge clk); while (!pt_in.ready);
    pending_results.push_back(transform_point(cmd, x, y, z));
    @(negedge clk);
  endtask

  // wait for the pipe to empty; registers may change afterwards
  task automatic drain();
    pt_in.valid = 1'b0;
    while (pending_results.size() != 0)
      @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // receiver stalls at random
  always @(negedge clk)
    pt_out.ready <= ($urandom_range(99) >= recv_stall_pct);

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    point_result_t e;
    if (!rst && pt_out.valid && pt_out.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (pt_out.x_out !== e.x) begin
          $error("x_out expected %h got %h", e.x, pt_out.x_out);
          error_count++;
        end
        if (pt_out.y_out !== e.y) begin
          $error("y_out expected %h got %h", e.y, pt_out.y_out);
          error_count++;
        end
        if (pt_out.z_out !== e.z) begin
          $error("z_out expected %h got %h", e.z, pt_out.z_out);
          error_count++;
        end
        if (pt_out.divided !== e.divided) begin
          $error("divided expected %b got %b", e.divided, pt_out.divided);
          error_count++;
        end
        if (pt_out.saturated !== e.saturated) begin
          $error("saturated expected %b got %b", e.saturated, pt_out.saturated);
          error_count++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(262143)) - 131072);
      2: return 32'($signed($urandom_range(8388607)) - 4194304);
      3: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
      4: return ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(2 * ONE)) - ONE);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(4 * ONE)) - 2 * ONE);
      2: return 32'($signed($urandom_range(512)) - 256);
      3: return 32'h0;
      default: return ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  task automatic load_identity();
    for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
      write_reg(i, 64'h0);
    write_reg(hpt_pkg::REG_ROW0_COLS01, 64'(ONE));
    write_reg(hpt_pkg::REG_ROW1_COLS01, 64'(ONE) << 32);
    write_reg(hpt_pkg::REG_ROW2_COLS23, 64'(ONE));
    write_reg(hpt_pkg::REG_ROW3_COLS23, 64'(ONE) << 32);
  endtask

  // random matrix; sometimes keep the bottom row affine so w stays near one
  task automatic load_random_matrix();
    bit affine;
    affine = ($urandom_range(2) == 0);
    for (int i = 0; i < hpt_pkg::NUM_REGS - 2; i++)
      write_reg(i, {rand_coef(), rand_coef()});
    if (affine) begin
      write_reg(hpt_pkg::REG_ROW3_COLS01, 64'h0);
      write_reg(hpt_pkg::REG_ROW3_COLS23,
                {32'(ONE + $signed($urandom_range(4)) - 2), 32'h0});
    end else begin
      write_reg(hpt_pkg::REG_ROW3_COLS01, {rand_coef(), rand_coef()});
      write_reg(hpt_pkg::REG_ROW3_COLS23, {rand_coef(), rand_coef()});
    end
  endtask

  // identity after reset: coordinate extremes, both commands
  task automatic test_reset_identity();
    logic [31:0] corner [5] = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'(ONE)};
    for (int i = 0; i < 5; i++) begin
      send_point(CMD_POINT, corner[i], corner[(i + 1) % 5], corner[(i + 2) % 5]);
      send_point(CMD_DIR, corner[i], corner[(i + 3) % 5], corner[(i + 4) % 5]);
    end
    drain();
  endtask

  // perspective matrix with w = z: w near zero, near one, and a real divide
  task automatic test_perspective_divide();
    write_reg(hpt_pkg::REG_ROW3_COLS01, 64'h0);
    write_reg(hpt_pkg::REG_ROW3_COLS23, {32'h0, 32'(ONE)});
    write_reg(hpt_pkg::REG_ROW0_COLS23, {32'(5 * ONE), 32'h0});
    send_point(CMD_POINT, 32'(3 * ONE), 32'(ONE), 32'(2 * ONE));  // real divide
    send_point(CMD_POINT, 32'(ONE), 32'(ONE), 32'h1);              // w one lsb from zero
    send_point(CMD_POINT, 32'(ONE), 32'(ONE), 32'hffff_ffff);      // w minus one lsb
    send_point(CMD_POINT, 32'(ONE), 32'(ONE), 32'(ONE + 1));       // w just over one
    send_point(CMD_POINT, 32'(ONE), 32'(ONE), 32'(ONE - 1));       // w just under one
    send_point(CMD_POINT, 32'(ONE), 32'(ONE), 32'(ONE + 2));       // divide applies
    send_point(CMD_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h2);    // huge quotient
    send_point(CMD_POINT, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_fffe);
    send_point(CMD_DIR, 32'(3 * ONE), 32'(ONE), 32'h2);            // direction never divides
    drain();
  endtask

  // extreme coefficients drive the sums far out of range
  task automatic test_saturation();
    for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
      write_reg(i, (i % 2) ? 64'h8000_0000_7fff_ffff : 64'h7fff_ffff_8000_0000);
    send_point(CMD_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_point(CMD_DIR, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_point(CMD_POINT, 32'h0, 32'h0, 32'h0);
    drain();
    for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
      write_reg(i, 64'hffff_ffff_ffff_ffff);
    send_point(CMD_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(CMD_DIR, 32'hffff_ffff, 32'h1, 32'h8000_0000);
    drain();
  endtask

  // random matrices and points under one idling pattern
  task automatic test_random_stream(int send_pct, int stall_pct, int n_items);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int m = 0; m < 5; m++) begin
      load_random_matrix();
      for (int i = 0; i < n_items / 5; i++)
        send_point(($urandom_range(3) == 0) ? CMD_DIR : CMD_POINT,
                   rand_coord(), rand_coord(), rand_coord());
      drain();
    end
  endtask

  initial begin
    rst            = 1'b1;
    error_count    = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cfg.valid      = 1'b0;
    cfg.index      = '0;
    cfg.data       = '0;
    pt_in.valid    = 1'b0;
    pt_in.cmd      = CMD_POINT;
    pt_in.x_in     = '0;
    pt_in.y_in     = '0;
    pt_in.z_in     = '0;
    // identity is the state after reset
    for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
      matrix[i] = 64'h0;
    matrix[hpt_pkg::REG_ROW0_COLS01] = 64'(ONE);
    matrix[hpt_pkg::REG_ROW1_COLS01] = 64'(ONE) << 32;
    matrix[hpt_pkg::REG_ROW2_COLS23] = 64'(ONE);
    matrix[hpt_pkg::REG_ROW3_COLS23] = 64'(ONE) << 32;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_identity();
    test_perspective_divide();
    test_saturation();
    load_identity();
    test_random_stream(0, 0, 450);
    test_random_stream(60, 0, 450);
    test_random_stream(0, 60, 450);
    test_random_stream(22, 22, 450);

    drain();
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: homogeneous_point_transform.f
hw/rtl/hpt_pkg.sv
hw/rtl/hpt_if.sv
hw/rtl/hpt_div_pipe.sv
hw/rtl/homogeneous_point_transform.sv
tb/tb.sv
